FILE: rtl/enigma_letter_cipher_macros.svh
// ============================================================================
// Assertion macros for the rotor cipher
// Short forms for the concurrent assertions used in the cipher's RTL.
// ============================================================================
`ifndef ENIGMA_LETTER_CIPHER_MACROS_SVH
`define ENIGMA_LETTER_CIPHER_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define ELC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ELC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ELC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/elc_pkg.sv
// ============================================================================
// Rotor cipher package
// Shared constants, field widths and types of the rotor cipher.
// ============================================================================
package elc_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int ROTOR_KINDS_DEF   = 5;

    localparam int ACTION_W = 2;
    localparam int SELECT_W = 3;
    localparam int LETTER_W = 5;
    localparam int CHOICE_W = 3;

    // Item actions.
    localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ENCRYPT = 2'd2;

    // Table selects beyond the rotor wirings.
    localparam logic [SELECT_W-1:0] TBL_PLUG = 3'd5;
    localparam logic [SELECT_W-1:0] TBL_REFL = 3'd6;

    // Reset values of the rotor choice registers.
    localparam logic [CHOICE_W-1:0] LEFT_CHOICE_RST   = 3'd0;
    localparam logic [CHOICE_W-1:0] MIDDLE_CHOICE_RST = 3'd1;
    localparam logic [CHOICE_W-1:0] RIGHT_CHOICE_RST  = 3'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SELECT_W-1:0] table_select;
        logic [LETTER_W-1:0] entry_index;
        logic [LETTER_W-1:0] entry_value;
        logic [LETTER_W-1:0] plain_letter;
        logic [LETTER_W-1:0] start_left;
        logic [LETTER_W-1:0] start_middle;
        logic [LETTER_W-1:0] start_right;
    } t_item;

    typedef struct packed {
        logic take;
        logic res_valid;
    } t_core_stat;

endpackage

FILE: rtl/elc_core.sv
// ============================================================================
// Rotor cipher core
// Wiring tables in two memories, rotor positions and the letter walk.
// ============================================================================
module elc_core #(
    parameter int ALPHABET_SIZE = elc_pkg::ALPHABET_SIZE_DEF,
    parameter int ROTOR_KINDS   = elc_pkg::ROTOR_KINDS_DEF,
    parameter int LW            = $clog2(ALPHABET_SIZE)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  elc_pkg::t_item                i_item,
    input  logic [elc_pkg::CHOICE_W-1:0]  i_left_choice,
    input  logic [elc_pkg::CHOICE_W-1:0]  i_middle_choice,
    input  logic [elc_pkg::CHOICE_W-1:0]  i_right_choice,
    input  logic                          i_res_ready,
    output elc_pkg::t_core_stat           o_stat,
    output logic [LW-1:0]                 o_res_letter
);
    import elc_pkg::*;

    `include "enigma_letter_cipher_macros.svh"

    localparam int KW        = (ROTOR_KINDS > 1) ? $clog2(ROTOR_KINDS) : 1;
    localparam int FWD_DEPTH = (ROTOR_KINDS + 2) * ALPHABET_SIZE;
    localparam int INV_DEPTH = (ROTOR_KINDS + 1) * ALPHABET_SIZE;
    localparam int FAW       = $clog2(FWD_DEPTH);
    localparam int IAW       = $clog2(INV_DEPTH);

    localparam logic [FAW-1:0] F_PLUG_BASE = FAW'(ROTOR_KINDS * ALPHABET_SIZE);
    localparam logic [FAW-1:0] F_REFL_BASE = FAW'((ROTOR_KINDS + 1) * ALPHABET_SIZE);
    localparam logic [IAW-1:0] I_PLUG_BASE = IAW'(ROTOR_KINDS * ALPHABET_SIZE);
    localparam logic [FAW-1:0] F_ALPHA     = FAW'(ALPHABET_SIZE);
    localparam logic [IAW-1:0] I_ALPHA     = IAW'(ALPHABET_SIZE);
    localparam logic [LW:0]    A_EXT       = (LW + 1)'(ALPHABET_SIZE);
    localparam logic [LETTER_W:0] A_FIELD  = (LETTER_W + 1)'(ALPHABET_SIZE);
    localparam logic [SELECT_W:0] K_FIELD  = (SELECT_W + 1)'(ROTOR_KINDS);
    localparam logic [LW-1:0]  NOTCH       = LW'(ALPHABET_SIZE - 1);

    // Walk steps: one table read each, the last one only collects the result.
    localparam logic [3:0] STEP_PLUG_F = 4'd0;
    localparam logic [3:0] STEP_R_F    = 4'd1;
    localparam logic [3:0] STEP_M_F    = 4'd2;
    localparam logic [3:0] STEP_L_F    = 4'd3;
    localparam logic [3:0] STEP_REFL   = 4'd4;
    localparam logic [3:0] STEP_L_I    = 4'd5;
    localparam logic [3:0] STEP_M_I    = 4'd6;
    localparam logic [3:0] STEP_R_I    = 4'd7;
    localparam logic [3:0] STEP_PLUG_I = 4'd8;
    localparam logic [3:0] STEP_DONE   = 4'd9;

    localparam logic [1:0] SLOT_RIGHT  = 2'd0;
    localparam logic [1:0] SLOT_MIDDLE = 2'd1;
    localparam logic [1:0] SLOT_LEFT   = 2'd2;

    typedef enum logic {S_IDLE, S_WALK} t_state;

    function automatic logic [1:0] slot_of(input logic [3:0] s);
        logic [1:0] r;
        case (s)
            STEP_R_F, STEP_R_I: r = SLOT_RIGHT;
            STEP_M_F, STEP_M_I: r = SLOT_MIDDLE;
            default:            r = SLOT_LEFT;
        endcase
        return r;
    endfunction

    function automatic logic is_rotor(input logic [3:0] s);
        return s inside {STEP_R_F, STEP_M_F, STEP_L_F, STEP_L_I, STEP_M_I, STEP_R_I};
    endfunction

    t_state          r_state;
    logic [3:0]      r_step;
    logic [LW-1:0]   r_pos_left, r_pos_middle, r_pos_right;

    logic [LW-1:0]   mem_fwd [FWD_DEPTH];
    logic [LW-1:0]   mem_inv [INV_DEPTH];
    logic [LW-1:0]   r_fwd_rd, r_inv_rd;

    logic [LW-1:0]   w_mod_a [32];
    logic [KW-1:0]   w_mod_k [8];
    logic [KW-1:0]   w_kind  [3];
    logic [LW-1:0]   w_pos   [3];

    logic            w_take, w_load, w_sel_rotor;
    logic [LW-1:0]   w_idx, w_val;
    logic            w_fwd_we, w_inv_we, w_fwd_re, w_inv_re, w_issue;
    logic [FAW-1:0]  w_fwd_waddr, w_fwd_raddr;
    logic [IAW-1:0]  w_inv_waddr, w_inv_raddr;
    logic [3:0]      w_prev, w_cur;
    logic [LW-1:0]   w_rd, w_back, w_y, w_shift, w_back_pos, w_cur_pos;
    logic [LW:0]     w_back_sum, w_fwd_sum;
    logic [KW-1:0]   w_cur_kind;

    // Reduction tables for five-bit letters and three-bit rotor choices.
    for (genvar g = 0; g < 32; g++) begin : g_mod_a
        assign w_mod_a[g] = LW'(g % ALPHABET_SIZE);
    end
    for (genvar g = 0; g < 8; g++) begin : g_mod_k
        assign w_mod_k[g] = KW'(g % ROTOR_KINDS);
    end

    assign w_kind[SLOT_RIGHT]  = w_mod_k[i_right_choice];
    assign w_kind[SLOT_MIDDLE] = w_mod_k[i_middle_choice];
    assign w_kind[SLOT_LEFT]   = w_mod_k[i_left_choice];
    assign w_pos[SLOT_RIGHT]   = r_pos_right;
    assign w_pos[SLOT_MIDDLE]  = r_pos_middle;
    assign w_pos[SLOT_LEFT]    = r_pos_left;

    // Table loads: a rotor or plugboard entry also writes its inverse entry.
    always_comb begin
        w_take      = i_item_valid && (r_state == S_IDLE);
        w_idx       = i_item.entry_index[LW-1:0];
        w_val       = i_item.entry_value[LW-1:0];
        w_sel_rotor = {1'b0, i_item.table_select} < K_FIELD;
        w_load      = w_take && (i_item.action == ACT_LOAD)
                      && ({1'b0, i_item.entry_index} < A_FIELD)
                      && ({1'b0, i_item.entry_value} < A_FIELD);
        w_fwd_we    = w_load && (w_sel_rotor || i_item.table_select == TBL_PLUG
                                 || i_item.table_select == TBL_REFL);
        w_inv_we    = w_load && (w_sel_rotor || i_item.table_select == TBL_PLUG);
        if (w_sel_rotor) begin
            w_fwd_waddr = FAW'(KW'(i_item.table_select)) * F_ALPHA + FAW'(w_idx);
            w_inv_waddr = IAW'(KW'(i_item.table_select)) * I_ALPHA + IAW'(w_val);
        end else if (i_item.table_select == TBL_PLUG) begin
            w_fwd_waddr = F_PLUG_BASE + FAW'(w_idx);
            w_inv_waddr = I_PLUG_BASE + IAW'(w_val);
        end else begin
            w_fwd_waddr = F_REFL_BASE + FAW'(w_idx);
            w_inv_waddr = I_PLUG_BASE + IAW'(w_val);
        end
    end

    // Letter walk: undo the shift of the read just returned, then shift
    // into the next table and issue its read.
    always_comb begin
        w_prev     = r_step - 4'd1;
        w_rd       = (w_prev <= STEP_REFL) ? r_fwd_rd : r_inv_rd;
        w_back_pos = w_pos[slot_of(w_prev)];
        w_back_sum = {1'b0, w_rd} + (A_EXT - {1'b0, w_back_pos});
        w_back     = (w_back_sum >= A_EXT) ? LW'(w_back_sum - A_EXT) : w_back_sum[LW-1:0];
        if (r_state == S_IDLE) begin
            w_y   = w_mod_a[i_item.plain_letter];
            w_cur = STEP_PLUG_F;
        end else begin
            w_y   = is_rotor(w_prev) ? w_back : w_rd;
            w_cur = r_step;
        end
        w_cur_pos  = w_pos[slot_of(w_cur)];
        w_cur_kind = w_kind[slot_of(w_cur)];
        w_fwd_sum  = {1'b0, w_y} + {1'b0, w_cur_pos};
        w_shift    = (w_fwd_sum >= A_EXT) ? LW'(w_fwd_sum - A_EXT) : w_fwd_sum[LW-1:0];
        w_fwd_raddr = FAW'(w_cur_kind) * F_ALPHA + FAW'(w_shift);
        w_inv_raddr = IAW'(w_cur_kind) * I_ALPHA + IAW'(w_shift);
        case (w_cur)
            STEP_PLUG_F: w_fwd_raddr = F_PLUG_BASE + FAW'(w_y);
            STEP_REFL:   w_fwd_raddr = F_REFL_BASE + FAW'(w_y);
            STEP_PLUG_I: w_inv_raddr = I_PLUG_BASE + IAW'(w_y);
            default:     ;
        endcase
        w_issue  = (w_take && i_item.action == ACT_ENCRYPT)
                   || (r_state == S_WALK && r_step <= STEP_PLUG_I);
        w_fwd_re = w_issue && (w_cur <= STEP_REFL);
        w_inv_re = w_issue && (w_cur > STEP_REFL);
    end

    always_ff @(posedge i_clk) begin
        if (w_fwd_we) begin
            mem_fwd[w_fwd_waddr] <= w_val;
        end
        if (w_fwd_re) begin
            r_fwd_rd <= mem_fwd[w_fwd_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_inv_we) begin
            mem_inv[w_inv_waddr] <= w_idx;
        end
        if (w_inv_re) begin
            r_inv_rd <= mem_inv[w_inv_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= STEP_PLUG_F;
            r_pos_left   <= '0;
            r_pos_middle <= '0;
            r_pos_right  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        case (i_item.action)
                            ACT_SET: begin
                                r_pos_left   <= w_mod_a[i_item.start_left];
                                r_pos_middle <= w_mod_a[i_item.start_middle];
                                r_pos_right  <= w_mod_a[i_item.start_right];
                            end
                            ACT_ENCRYPT: begin
                                r_state <= S_WALK;
                                r_step  <= STEP_R_F;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK: begin
                    if (r_step != STEP_DONE) begin
                        r_step <= r_step + 4'd1;
                    end else if (i_res_ready) begin
                        r_state <= S_IDLE;
                        r_step  <= STEP_PLUG_F;
                        // Odometer stepping with the notch on the last letter.
                        if (r_pos_right == NOTCH) begin
                            if (r_pos_middle == NOTCH) begin
                                r_pos_left <= (r_pos_left == NOTCH) ? '0 : r_pos_left + 1'b1;
                            end
                            r_pos_middle <= (r_pos_middle == NOTCH) ? '0 : r_pos_middle + 1'b1;
                        end
                        r_pos_right <= (r_pos_right == NOTCH) ? '0 : r_pos_right + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.take      = w_take;
    assign o_stat.res_valid = (r_state == S_WALK) && (r_step == STEP_DONE);
    assign o_res_letter     = w_y;

    `ELC_ASSERT_ALWAYS(a_pos_range, i_clk, i_rst_n,
        ({1'b0, r_pos_left} < A_EXT) && ({1'b0, r_pos_middle} < A_EXT) && ({1'b0, r_pos_right} < A_EXT),
        "rotor position outside the alphabet")
    `ELC_ASSERT_IMPLY(a_no_take_in_walk, i_clk, i_rst_n,
        r_state == S_WALK, !o_stat.take,
        "item taken while a letter walk is running")
    `ELC_ASSERT_IMPLY(a_step_range, i_clk, i_rst_n,
        r_state == S_WALK, (r_step != STEP_PLUG_F) && (r_step <= STEP_DONE),
        "walk step counter out of range")
    `ELC_ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n,
        o_stat.res_valid && i_res_ready, r_state == S_IDLE,
        "walk did not end after its result was handed over")

endmodule

FILE: rtl/enigma_letter_cipher.sv
// ============================================================================
// Three-slot rotor cipher
// Streaming letter cipher with loadable wiring tables and an APB register port.
// ============================================================================
// Use: words enter on the s_axis channel; s_axis_tuser carries the action
// (load table entry, set rotor positions, encrypt letter). Load and set
// words produce no output word; each encrypt word produces one cipher letter
// on the m_axis channel. The three rotor choice registers sit on the APB
// port at byte addresses 0, 4 and 8; the user must write them only while the
// block is idle, as the block itself does not enforce this.
// Rate: load and set words flow at one per cycle while no letter is under
// way. An encrypt word walks through nine dependent table reads, one per
// cycle, out of two synchronous wiring memories (forward and inverse) with
// one read port each, and the core takes no new word until its letter has
// been handed to the output register.
// A one-word input buffer takes the next word while a letter is under way,
// and an output register holds a finished letter while the next one is
// worked on. If the receiver stalls, the finished letter waits in the core
// until the output register frees up; nothing is dropped.
// Reset clears the rotor positions to zero and the choices to 0, 1 and 2;
// the wiring tables keep no reset value and must be loaded before use.
module enigma_letter_cipher #(
    parameter int ALPHABET_SIZE = elc_pkg::ALPHABET_SIZE_DEF,
    parameter int ROTOR_KINDS   = elc_pkg::ROTOR_KINDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, from bit 0: table_select[2:0], entry_index[7:3], entry_value[12:8],
    // plain_letter[17:13], start_left[22:18], start_middle[27:23],
    // start_right[32:28], zero fill[39:33].
    input  logic [39:0] s_axis_tdata,
    // tuser, from bit 0: action[1:0].
    input  logic [1:0]  s_axis_tuser,
    // Output channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, from bit 0: cipher_letter[4:0], zero fill[7:5].
    output logic [7:0]  m_axis_tdata,
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import elc_pkg::*;

    localparam int LW = $clog2(ALPHABET_SIZE);

    // Register indexes on paddr[3:2].
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_MIDDLE = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;

    logic [CHOICE_W-1:0] r_left_choice, r_middle_choice, r_right_choice;
    logic                r_buf_valid;
    t_item               r_buf;
    logic                r_out_valid;
    logic [LETTER_W-1:0] r_out_letter;

    t_core_stat          w_stat;
    logic [LW-1:0]       w_res_letter;
    logic                w_res_ready;
    logic                w_cfg_write;
    t_item               w_in_item;

    // The register port never waits.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_choice   <= LEFT_CHOICE_RST;
            r_middle_choice <= MIDDLE_CHOICE_RST;
            r_right_choice  <= RIGHT_CHOICE_RST;
        end else if (w_cfg_write) begin
            case (paddr[3:2])
                REG_LEFT:   r_left_choice   <= pwdata[CHOICE_W-1:0];
                REG_MIDDLE: r_middle_choice <= pwdata[CHOICE_W-1:0];
                REG_RIGHT:  r_right_choice  <= pwdata[CHOICE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LEFT:   prdata = {29'd0, r_left_choice};
            REG_MIDDLE: prdata = {29'd0, r_middle_choice};
            REG_RIGHT:  prdata = {29'd0, r_right_choice};
            default:    prdata = 32'd0;
        endcase
    end

    // Unpack the incoming word.
    always_comb begin
        w_in_item.action       = s_axis_tuser;
        w_in_item.table_select = s_axis_tdata[2:0];
        w_in_item.entry_index  = s_axis_tdata[7:3];
        w_in_item.entry_value  = s_axis_tdata[12:8];
        w_in_item.plain_letter = s_axis_tdata[17:13];
        w_in_item.start_left   = s_axis_tdata[22:18];
        w_in_item.start_middle = s_axis_tdata[27:23];
        w_in_item.start_right  = s_axis_tdata[32:28];
    end

    // The input buffer refills in the same cycle that the core empties it.
    assign s_axis_tready = !r_buf_valid || w_stat.take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_buf_valid <= 1'b1;
        end else if (w_stat.take) begin
            r_buf_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_buf <= w_in_item;
        end
    end

    elc_core #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ROTOR_KINDS   (ROTOR_KINDS),
        .LW            (LW)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (r_buf_valid),
        .i_item          (r_buf),
        .i_left_choice   (r_left_choice),
        .i_middle_choice (r_middle_choice),
        .i_right_choice  (r_right_choice),
        .i_res_ready     (w_res_ready),
        .o_stat          (w_stat),
        .o_res_letter    (w_res_letter)
    );

    // Output register: takes a new letter when empty or being emptied.
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.res_valid && w_res_ready) begin
            r_out_letter <= LETTER_W'(w_res_letter);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out_letter};

endmodule

FILE: verif/tb_enigma_letter_cipher.sv
// ============================================================================
// Rotor cipher testbench
// Loads every wiring table and then drives load, set and encrypt words with
// bursty input and a stalling receiver. A scoreboard predicts each cipher
// letter and checks the output channel against it.
// ============================================================================
module tb_enigma_letter_cipher;

    timeunit 1ns;
    timeprecision 1ps;

    import elc_pkg::*;

    localparam int LETTERS = ALPHABET_SIZE_DEF;
    localparam int KINDS   = ROTOR_KINDS_DEF;
    localparam int NOTCH   = LETTERS - 1;

    // Register indexes. They double as slot indexes inside the scoreboard.
    localparam int REG_LEFT   = 0;
    localparam int REG_MIDDLE = 1;
    localparam int REG_RIGHT  = 2;

    // The one action code that the block ignores.
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    // One more word may sit in the input buffer behind a letter still in the
    // core, so this covers anything still in flight.
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 215;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the wiring tables, rotor positions and
    // rotor choices, and queues the cipher letter each encrypt word must give.
    // ------------------------------------------------------------------------
    class cipher_tracker;
        logic [4:0] wiring_fwd [KINDS*LETTERS];
        logic [4:0] wiring_inv [KINDS*LETTERS];
        logic [4:0] plug_fwd   [LETTERS];
        logic [4:0] plug_inv   [LETTERS];
        logic [4:0] reflect    [LETTERS];
        int         pos        [3];
        logic [2:0] choice     [3];
        logic [4:0] expected_letters [$];
        int         errors;

        function new();
            pos       = '{0, 0, 0};
            choice    = '{LEFT_CHOICE_RST, MIDDLE_CHOICE_RST, RIGHT_CHOICE_RST};
            errors    = 0;
        endfunction

        function void set_choice(int slot, logic [2:0] v);
            choice[slot] = v;
        endfunction

        function int pending();
            return expected_letters.size();
        endfunction

        // One pass through the rotor in a slot, forward or on the way back.
        function int rotor_pass(bit backward, int slot, int x);
            int kind;
            int shifted;
            int mapped;
            kind    = choice[slot] % KINDS;
            shifted = (x + pos[slot]) % LETTERS;
            mapped  = backward ? wiring_inv[kind*LETTERS + shifted]
                               : wiring_fwd[kind*LETTERS + shifted];
            return (mapped + LETTERS - pos[slot]) % LETTERS;
        endfunction

        // Odometer stepping; the left rotor only moves on a double notch.
        function void advance();
            if (pos[REG_RIGHT] == NOTCH) begin
                if (pos[REG_MIDDLE] == NOTCH)
                    pos[REG_LEFT] = (pos[REG_LEFT] + 1) % LETTERS;
                pos[REG_MIDDLE] = (pos[REG_MIDDLE] + 1) % LETTERS;
            end
            pos[REG_RIGHT] = (pos[REG_RIGHT] + 1) % LETTERS;
        endfunction

        function void note_word(t_item w);
            int x;
            int idx;
            int val;
            int sel;
            case (w.action)
                ACT_LOAD: begin
                    idx = w.entry_index;
                    val = w.entry_value;
                    sel = w.table_select;
                    if (idx < LETTERS && val < LETTERS) begin
                        if (sel < KINDS) begin
                            wiring_fwd[sel*LETTERS + idx] = 5'(val);
                            wiring_inv[sel*LETTERS + val] = 5'(idx);
                        end else if (sel == TBL_PLUG) begin
                            plug_fwd[idx] = 5'(val);
                            plug_inv[val] = 5'(idx);
                        end else if (sel == TBL_REFL) begin
                            reflect[idx] = 5'(val);
                        end
                    end
                end
                ACT_SET: begin
                    pos[REG_LEFT]   = w.start_left % LETTERS;
                    pos[REG_MIDDLE] = w.start_middle % LETTERS;
                    pos[REG_RIGHT]  = w.start_right % LETTERS;
                end
                ACT_ENCRYPT: begin
                    x = w.plain_letter % LETTERS;
                    x = plug_fwd[x];
                    x = rotor_pass(1'b0, REG_RIGHT, x);
                    x = rotor_pass(1'b0, REG_MIDDLE, x);
                    x = rotor_pass(1'b0, REG_LEFT, x);
                    x = reflect[x];
                    x = rotor_pass(1'b1, REG_LEFT, x);
                    x = rotor_pass(1'b1, REG_MIDDLE, x);
                    x = rotor_pass(1'b1, REG_RIGHT, x);
                    x = plug_inv[x];
                    expected_letters.push_back(5'(x));
                    advance();
                end
                default: ;
            endcase
        endfunction

        function void check_letter(logic [4:0] got);
            logic [4:0] want;
            if (expected_letters.size() == 0) begin
                $error("cipher_letter: no letter expected, actual %0d", got);
                errors++;
                return;
            end
            want = expected_letters.pop_front();
            if (got !== want) begin
                $error("cipher_letter: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block. Every input starts at a
    // known value; the reset starts low and is raised by the test sequence.
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata, from bit 0: table_select[2:0], entry_index[7:3], entry_value[12:8],
    // plain_letter[17:13], start_left[22:18], start_middle[27:23],
    // start_right[32:28], zero fill[39:33].
    logic [39:0] s_axis_tdata  = '0;
    // tuser, from bit 0: action[1:0].
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata, from bit 0: cipher_letter[4:0], zero fill[7:5].
    logic [7:0]  m_axis_tdata;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    cipher_tracker tracker;

    // Sender pacing: a burst of words, then a gap, while gaps are enabled.
    bit gaps_on    = 1'b1;
    int burst_left = 1;

    // Receiver pacing and the watchdog.
    int stall_mode  = 0;
    int stall_left  = 0;
    int quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    enigma_letter_cipher u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Word builders. Fields that a word's action does not use are still
    // filled with random bits, so that the block is seen to ignore them.
    // ------------------------------------------------------------------------
    function automatic t_item raw_word();
        t_item w;
        w.action       = $urandom_range(0, 3);
        w.table_select = $urandom_range(0, 7);
        w.entry_index  = $urandom_range(0, 31);
        w.entry_value  = $urandom_range(0, 31);
        w.plain_letter = $urandom_range(0, 31);
        w.start_left   = $urandom_range(0, 31);
        w.start_middle = $urandom_range(0, 31);
        w.start_right  = $urandom_range(0, 31);
        return w;
    endfunction

    function automatic t_item load_word(int sel, int idx, int val);
        t_item w;
        w              = raw_word();
        w.action       = ACT_LOAD;
        w.table_select = 3'(sel);
        w.entry_index  = 5'(idx);
        w.entry_value  = 5'(val);
        return w;
    endfunction

    function automatic t_item set_word(int l, int m, int r);
        t_item w;
        w              = raw_word();
        w.action       = ACT_SET;
        w.start_left   = 5'(l);
        w.start_middle = 5'(m);
        w.start_right  = 5'(r);
        return w;
    endfunction

    function automatic t_item letter_word(int p);
        t_item w;
        w              = raw_word();
        w.action       = ACT_ENCRYPT;
        w.plain_letter = 5'(p);
        return w;
    endfunction

    // Positions are drawn near the notch a third of the time so that the
    // middle and left rotors step often.
    function automatic int pick_position();
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(NOTCH - 3, NOTCH);
        return $urandom_range(0, NOTCH);
    endfunction

    // Mostly well-formed words with random content; the rest is raw noise,
    // which brings in out-of-range letters, unknown tables and the ignored
    // action.
    function automatic t_item random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return letter_word($urandom_range(0, NOTCH));
        if (r < 67)
            return set_word(pick_position(), pick_position(), pick_position());
        if (r < 85)
            return load_word($urandom_range(0, TBL_REFL), $urandom_range(0, NOTCH),
                             $urandom_range(0, NOTCH));
        return raw_word();
    endfunction

    // ------------------------------------------------------------------------
    // Input channel. A word is driven at a rising edge and held until the
    // edge at which tready is seen high; the scoreboard learns of it there.
    // tvalid is only lowered by an explicit gap, so back-to-back words never
    // see it dropped and raised within one time step.
    // ------------------------------------------------------------------------
    task automatic push_word(input t_item w);
        s_axis_tdata  <= {7'd0, w.start_right, w.start_middle, w.start_left,
                          w.plain_letter, w.entry_value, w.entry_index, w.table_select};
        s_axis_tuser  <= w.action;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_word(w);
    endtask

    task automatic sender_gap(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic feed(input t_item w);
        push_word(w);
        if (gaps_on) begin
            if (burst_left <= 1) begin
                sender_gap($urandom_range(1, 9));
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stops sending and waits for every expected letter, then lets the last
    // load or set word drain out of the core.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Register port. The three choices are written back to back; psel stays
    // high between them so that each signal gets one assignment per step.
    // ------------------------------------------------------------------------
    task automatic write_choices(input logic [2:0] l, input logic [2:0] m,
                                 input logic [2:0] r);
        logic [2:0] vals [3];
        vals = '{l, m, r};
        for (int i = REG_LEFT; i <= REG_RIGHT; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= 4'(4 * i);
            pwdata  <= {29'd0, vals[i]};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            tracker.set_choice(i, vals[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Every wiring table gets a full random permutation before any letter
    // is encrypted, so no entry is ever read before it has been written.
    task automatic load_wirings();
        int perm [LETTERS];
        int j;
        int t;
        for (int sel = 0; sel <= TBL_REFL; sel++) begin
            for (int i = 0; i < LETTERS; i++)
                perm[i] = i;
            for (int i = LETTERS - 1; i > 0; i--) begin
                j       = $urandom_range(0, i);
                t       = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end
            for (int i = 0; i < LETTERS; i++)
                feed(load_word(sel, i, perm[i]));
        end
    endtask

    // Short directed run: letter extremes, wrapping of out-of-range letters
    // and positions, single and double notch steps, ignored loads, rewritten
    // entries and the ignored action.
    task automatic directed_words();
        t_item w;
        feed(set_word(0, 0, 0));
        feed(letter_word(0));
        feed(letter_word(NOTCH));
        feed(letter_word(26));
        feed(letter_word(31));
        // All three at the notch: every rotor steps on the next letter.
        feed(set_word(NOTCH, NOTCH, NOTCH));
        feed(letter_word(12));
        feed(letter_word(12));
        // Middle at the notch, right one short of it: the second letter
        // carries into the left rotor.
        feed(set_word(3, NOTCH, NOTCH - 1));
        feed(letter_word(7));
        feed(letter_word(7));
        feed(letter_word(7));
        // Start positions above the alphabet wrap round.
        feed(set_word(31, 26, 30));
        feed(letter_word(1));
        // Loads that must be ignored: unknown table, index or value too big.
        feed(load_word(7, 0, 1));
        feed(load_word(0, 26, 3));
        feed(load_word(5, 2, 31));
        feed(letter_word(4));
        // Rewritten entries leave the old inverse entry as it was.
        feed(load_word(0, 0, $urandom_range(0, NOTCH)));
        feed(load_word(TBL_PLUG, 3, $urandom_range(0, NOTCH)));
        feed(load_word(TBL_REFL, NOTCH, $urandom_range(0, NOTCH)));
        feed(letter_word(3));
        feed(letter_word(0));
        w        = raw_word();
        w.action = ACT_NONE;
        feed(w);
        feed(letter_word(NOTCH));
    endtask

    // ------------------------------------------------------------------------
    // Receiver: checks each accepted letter, then picks the next tready from
    // a stall pattern that is drawn anew whenever its run ends (always ready,
    // coin toss, or mostly stalled). Values read here are the ones present
    // just before the edge, as the block sees them.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_letter(m_axis_tdata[4:0]);
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog: too long without any word moving on either side means the
    // block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_enigma_letter_cipher: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence. After reset and the table load, each random phase runs
    // under its own rotor choices: all high, all low, out of range (reduced
    // modulo the number of rotors in the block) and fully random. The second
    // phase sends without gaps.
    // ------------------------------------------------------------------------
    initial begin
        logic [2:0] phase_cfg [4][3];
        t_item      w;
        int         sent;

        tracker = new();
        phase_cfg[0] = '{3'd4, 3'd4, 3'd4};
        phase_cfg[1] = '{3'd0, 3'd0, 3'd0};
        phase_cfg[2] = '{3'd7, 3'd5, 3'd6};
        phase_cfg[3] = '{3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                         3'($urandom_range(0, 7))};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_wirings();
        directed_words();

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_choices(phase_cfg[ph][REG_LEFT], phase_cfg[ph][REG_MIDDLE],
                          phase_cfg[ph][REG_RIGHT]);
            gaps_on = (ph != 1);
            sent    = 0;
            while (sent < PHASE_WORDS) begin
                w = random_word();
                feed(w);
                if (w.action != ACT_NONE)
                    sent++;
            end
        end

        drain();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb_enigma_letter_cipher: done, clean");
        else
            $display("tb_enigma_letter_cipher: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/elc_pkg.sv
rtl/elc_core.sv
rtl/enigma_letter_cipher.sv
verif/tb_enigma_letter_cipher.sv
